// ===== sv/aamd_pkg.sv =====
// Shared types, constants and the segment table for the averaging voltmeter.
`timescale 1ns / 1ps
package aamd_pkg;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 20;
	localparam int COUNT_W  = 8;
	localparam int FS_W     = 14;
	localparam int SEL_W    = 3;
	localparam int DIGIT_W  = 4;
	localparam int SEG_W    = 7;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	// The averaging divider takes the running sum over the sample count.
	localparam int NUM_W     = SUM_W;
	localparam int DEN_W     = COUNT_W;
	localparam int DIV_CNT_W = $clog2(NUM_W);

	// The scaled product keeps its low 32 bits; divided by 4095 it fits in 21 bits.
	localparam int PROD_W    = 32;
	localparam int FOLD_HI_W = PROD_W - SAMPLE_W;
	localparam int MV_W      = FOLD_HI_W + 1;
	localparam int FOLD_W    = SAMPLE_W + 1;

	// Division by ten is a multiply by ceil(2^24 / 10), exact for values below 2^22.
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = 2 * MV_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int NUM_DIGITS = 4;
	localparam int IDX_W      = $clog2(NUM_DIGITS);

	localparam logic [COUNT_W-1:0] SPA_RESET       = 8'd237;
	localparam logic [FS_W-1:0]    FS_RESET        = 14'd3300;
	localparam logic [FOLD_W-1:0]  CODE_FULL_SCALE = 13'd4095;
	localparam logic [MV_W-1:0]    DECIMAL_BASE    = 21'd10;
	localparam logic [MV_W-1:0]    RECIP_TEN       = 21'd1677722;

	// Register indexes on the configuration port.
	localparam logic [ADDR_W-3:0] REG_SPA = 1'b0;
	localparam logic [ADDR_W-3:0] REG_FS  = 1'b1;

	typedef struct packed {
		logic [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0] n;
	} blk_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'h0: s = 7'h3F;
			4'h1: s = 7'h06;
			4'h2: s = 7'h5B;
			4'h3: s = 7'h4F;
			4'h4: s = 7'h66;
			4'h5: s = 7'h6D;
			4'h6: s = 7'h7D;
			4'h7: s = 7'h07;
			4'h8: s = 7'h7F;
			4'h9: s = 7'h6F;
			4'hA: s = 7'h77;
			4'hB: s = 7'h7C;
			4'hC: s = 7'h39;
			4'hD: s = 7'h5E;
			4'hE: s = 7'h79;
			4'hF: s = 7'h71;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/aamd_div.sv =====
// Restoring divider for the average, one quotient bit per cycle.
`timescale 1ns / 1ps
module aamd_div
	import aamd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     quo_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W:0]       trial;
	logic [DEN_W:0]       diff;
	logic                 fits;
	logic                 last_step;

	assign trial     = {rem_q, quo_q[NUM_W-1]};
	assign diff      = trial - {1'b0, den_q};
	assign fits      = (trial >= {1'b0, den_q});
	assign last_step = (cnt_q == DIV_CNT_W'(NUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last_step) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== sv/aamd_queue.sv =====
// Short queue of finished sample blocks between the front and back parts.
`timescale 1ns / 1ps
module aamd_queue
	import aamd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  blk_t   push_data,
	input  logic   pop,
	output blk_t   pop_data,
	output qstat_t stat
);

	blk_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign stat.count = cnt_q;

endmodule

// ===== sv/aamd_front.sv =====
// Front part: accepts samples, keeps the running sum and closes each block.
`timescale 1ns / 1ps
module aamd_front
	import aamd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                in_stall,
	input  logic [COUNT_W-1:0]  samples_per_average,
	input  qstat_t              qstat,
	output logic                push,
	output blk_t                push_data
);

	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]   sum_next;
	logic [COUNT_W-1:0] cnt_next;
	logic [COUNT_W-1:0] n_eff;
	logic               accept;
	logic               block_end;

	// A full queue holds off every sample, whether or not it would close a block.
	assign in_stall  = qstat.full;
	assign accept    = in_valid && !in_stall;
	assign n_eff     = (samples_per_average == '0) ? COUNT_W'(1) : samples_per_average;
	assign sum_next  = sum_q + SUM_W'(sample);
	assign cnt_next  = cnt_q + 1'b1;
	// The block also ends when the count has passed a lowered setting.
	assign block_end = (cnt_next == '0) || (cnt_next >= n_eff);

	assign push           = accept && block_end;
	assign push_data.sum  = sum_next;
	assign push_data.n    = n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (block_end) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= sum_next;
				cnt_q <= cnt_next;
			end
		end
	end

endmodule

// ===== sv/aamd_back.sv =====
// Back part: averages, scales to millivolts and sends out the four digits.
`timescale 1ns / 1ps
module aamd_back
	import aamd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  blk_t               head,
	input  qstat_t             qstat,
	output logic               pop,
	input  logic [FS_W-1:0]    full_scale_mv,
	output div_req_t           div_req,
	input  div_rsp_t           div_rsp,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SEL_W-1:0]   digit_select,
	output logic [DIGIT_W-1:0] digit_value,
	output logic [SEG_W-1:0]   segments,
	output logic               point_on,
	output logic               last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_SCALE,
		ST_FOLD,
		ST_MV,
		ST_DIGIT,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic                 div_start_q;
	logic [NUM_W-1:0]     div_num_q;
	logic [DEN_W-1:0]     div_den_q;
	logic [SUM_W-1:0]     avg_q;
	logic [PROD_W-1:0]    prod_q;
	logic [FOLD_HI_W-1:0] fold_hi_q;
	logic [MV_W-1:0]      fold_sum_q;
	logic [MV_W-1:0]      mv_q;
	logic [MV_W-1:0]      quo_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 out_valid_q;
	logic [SEL_W-1:0]     digit_select_q;
	logic [DIGIT_W-1:0]   digit_value_q;
	logic [SEG_W-1:0]     segments_q;
	logic                 point_on_q;
	logic                 last_q;
	logic                 out_free;
	logic                 emit;
	logic                 last_digit;
	logic [FOLD_W-1:0]    fold_lo;
	logic                 fold_carry;
	logic [RECIP_W-1:0]   recip_prod;
	logic [MV_W-1:0]      digit_rem;
	logic [DIGIT_W-1:0]   digit;

	assign pop        = (state_q == ST_IDLE) && !qstat.empty;
	assign out_free   = !out_valid_q || !out_stall;
	assign emit       = (state_q == ST_EMIT) && out_free;
	assign last_digit = (idx_q == IDX_W'(NUM_DIGITS - 1));

	// Since 4096 = 4095 + 1, x / 4095 is the high part plus (high + low) / 4095;
	// folding twice leaves a value below twice 4095, settled by one compare.
	assign fold_lo    = FOLD_W'(fold_sum_q[MV_W-1:SAMPLE_W]) +
		FOLD_W'(fold_sum_q[SAMPLE_W-1:0]);
	assign fold_carry = (fold_lo >= CODE_FULL_SCALE);

	// Quotient by ten from the reciprocal, remainder by subtracting ten times it.
	assign recip_prod = RECIP_W'(mv_q) * RECIP_W'(RECIP_TEN);
	assign digit_rem  = mv_q - quo_q * DECIMAL_BASE;
	assign digit      = digit_rem[DIGIT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			div_start_q    <= 1'b0;
			div_num_q      <= '0;
			div_den_q      <= '0;
			avg_q          <= '0;
			prod_q         <= '0;
			fold_hi_q      <= '0;
			fold_sum_q     <= '0;
			mv_q           <= '0;
			quo_q          <= '0;
			idx_q          <= '0;
			out_valid_q    <= 1'b0;
			digit_select_q <= '0;
			digit_value_q  <= '0;
			segments_q     <= '0;
			point_on_q     <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			div_start_q <= pop;
			out_valid_q <= emit || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						div_num_q <= head.sum;
						div_den_q <= head.n;
						state_q   <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (div_rsp.done) begin
						avg_q   <= div_rsp.quo;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					prod_q  <= PROD_W'(avg_q) * PROD_W'(full_scale_mv);
					state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					fold_hi_q  <= prod_q[PROD_W-1:SAMPLE_W];
					fold_sum_q <= MV_W'(prod_q[PROD_W-1:SAMPLE_W]) +
						MV_W'(prod_q[SAMPLE_W-1:0]);
					state_q    <= ST_MV;
				end
				ST_MV: begin
					mv_q    <= MV_W'(fold_hi_q) + MV_W'(fold_sum_q[MV_W-1:SAMPLE_W]) +
						MV_W'(fold_carry);
					idx_q   <= '0;
					state_q <= ST_DIGIT;
				end
				ST_DIGIT: begin
					quo_q   <= MV_W'(recip_prod[RECIP_W-1:RECIP_SHIFT]);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						digit_select_q <= SEL_W'(NUM_DIGITS) - SEL_W'(idx_q);
						digit_value_q  <= digit;
						segments_q     <= seg_of(digit);
						point_on_q     <= last_digit;
						last_q         <= last_digit;
						if (last_digit) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							mv_q    <= quo_q;
							state_q <= ST_DIGIT;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign div_req.start = div_start_q;
	assign div_req.num   = div_num_q;
	assign div_req.den   = div_den_q;

	assign out_valid    = out_valid_q;
	assign digit_select = digit_select_q;
	assign digit_value  = digit_value_q;
	assign segments     = segments_q;
	assign point_on     = point_on_q;
	assign last         = last_q;

endmodule

// ===== sv/adc_average_millivolt_display.sv =====
// Top level of the averaging voltmeter with a four-digit seven-segment readout.
//
// Samples arrive as requests on the in_valid / in_stall channel, one 12-bit code
// each. The front part can take one request every cycle; it adds each sample to a
// running sum and, once samples_per_average samples are in, hands the sum to a
// two-entry queue. While that queue is full, in_stall is high.
// The back part pops a block and divides the sum by the count in a serial divider.
// It then scales the average by full scale over 4095 with a multiply and two
// folds of the 12-bit halves, and peels off each decimal digit by a multiply
// with the reciprocal of ten. Each further digit is offered only after the one
// before it is taken. The back part holds one block at a time until it has issued
// its thousands digit, which bounds the sustained rate when every sample closes a
// block; with longer blocks the sample rate sets it.
// Four result requests leave on out_valid / out_stall: units, tens, hundreds,
// thousands, with last and point_on set on the thousands digit. A result sits in
// the output register until the receiver drops out_stall; the back part then
// waits, the queue fills and the stall reaches the input side.
// Reset clears the running sum and count, the queue and all control state, and
// loads 237 samples per average and a 3300 mV full scale.
`timescale 1ns / 1ps
module adc_average_millivolt_display
	import aamd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [SEL_W-1:0]    digit_select,
	output logic [DIGIT_W-1:0]  digit_value,
	output logic [SEG_W-1:0]    segments,
	output logic                point_on,
	output logic                last
);

	logic [COUNT_W-1:0]  spa_q;
	logic [FS_W-1:0]     fs_q;
	logic [ADDR_W-3:0]   reg_idx;
	logic                cfg_write;
	logic                push;
	logic                pop;
	blk_t                push_data;
	blk_t                head;
	qstat_t              qstat;
	div_req_t            div_req;
	div_rsp_t            div_rsp;

	// Registers sit at word addresses, so the low two address bits are ignored.
	assign reg_idx   = paddr[ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spa_q <= SPA_RESET;
			fs_q  <= FS_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_SPA: spa_q <= pwdata[COUNT_W-1:0];
				REG_FS:  fs_q  <= pwdata[FS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SPA: prdata = DATA_W'(spa_q);
			REG_FS:  prdata = DATA_W'(fs_q);
			default: prdata = '0;
		endcase
	end

	aamd_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.sample              (sample),
		.in_stall            (in_stall),
		.samples_per_average (spa_q),
		.qstat               (qstat),
		.push                (push),
		.push_data           (push_data)
	);

	aamd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.stat      (qstat)
	);

	aamd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Live full scale; user changes it only with no block in flight, unchecked.
	aamd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.qstat         (qstat),
		.pop           (pop),
		.full_scale_mv (fs_q),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.digit_select  (digit_select),
		.digit_value   (digit_value),
		.segments      (segments),
		.point_on      (point_on),
		.last          (last)
	);

`ifndef SYNTHESIS
	a_digit_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digit_value <= DIGIT_W'(9)))
		else $error("digit out of decimal range");

	a_last_on_thousands: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == (digit_select == SEL_W'(1))))
		else $error("last flag not on the thousands digit");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(qstat.count <= QCNT_W'(QUEUE_DEPTH)) && !(push && qstat.full))
		else $error("block queue overflow");
`endif

endmodule
